/* hw/rtl/ssp_pkg.sv */
// Shared definitions for the serial servo pulse controller.
// Constants, register indexes, parser phase codes and the position command struct.
// No dependencies.
package ssp_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  // Packet framing.
  localparam logic [7:0] SYNC_BYTE    = 8'd255;
  localparam logic [7:0] COPY_ADDR    = 8'hFF;
  localparam logic [7:0] ADDR_MASK    = 8'd31;
  localparam logic [7:0] LIVE_LIMIT   = 8'd32;
  localparam logic [7:0] CACHE_LIMIT  = 8'd64;

  // Reset values.
  localparam logic [15:0] POS_RESET    = 16'd16000;
  localparam logic [15:0] PERIOD_RESET = 16'd40192;
  localparam logic [15:0] OFFSET_RESET = 16'd8000;
  localparam logic [15:0] LIMIT_RESET  = 16'd31000;
  localparam logic [1:0]  BOARD_RESET  = 2'd0;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BOARD_SELECT   = 2'd0;
  localparam logic [1:0] REG_SLOT_PERIOD    = 2'd1;
  localparam logic [1:0] REG_PULSE_OFFSET   = 2'd2;
  localparam logic [1:0] REG_POSITION_LIMIT = 2'd3;

  // Input item kinds.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_SKIP1 = 3'd4,
    PH_SKIP2 = 3'd5
  } phase_t;

  // Position update requested by a completed packet.
  typedef struct packed {
    logic        wr_live;
    logic        wr_cache;
    logic        copy_all;
    logic [15:0] value;
  } pos_cmd_t;

endpackage

/* hw/rtl/serial_servo_pulse_controller.sv */
// Top level of the serial servo pulse controller: handshake stages, registers, positions.
// Depends on ssp_pkg, ssp_parser and ssp_slot_timer.
//
//   Channel   Ports                                   Direction  Moves
//   input     in_valid/in_ready, in_action, in_rx_byte   in      one byte or tick item
//   result    out_valid/out_ready, out_servo_lines       out     line levels after the item
//   config    psel/penable/pwrite/paddr/pwdata/prdata    in/out  four registers on a 32-bit bus
//
// An accepted item is held in the input register and goes through the parser or timer
// logic into the result register when the result register is free or being taken.
// One item is accepted per cycle while the result side does not stall; the throughput
// is set by the single processing stage.
// Reset is synchronous and active low; positions return to their center values.
// A stalled result holds the processing stage, and the input register then fills.
module serial_servo_pulse_controller #(
  parameter int NUM_CHANNELS = ssp_pkg::NUM_CHANNELS_DEF,
  localparam int CW = $clog2(NUM_CHANNELS)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_servo_lines,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [1:0]  board_select_r;
  logic [15:0] slot_period_r;
  logic [15:0] pulse_offset_r;
  logic [15:0] position_limit_r;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  // Input register and result register.
  logic       s1_valid_r;
  logic       s1_action_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  logic [7:0] out_lines_r;
  logic       advance, process;

  // Position stores.
  logic [NUM_CHANNELS-1:0][15:0] live_pos_r;
  logic [NUM_CHANNELS-1:0][15:0] cache_pos_r;

  ssp_pkg::pos_cmd_t cmd;
  logic [CW-1:0]     cmd_chan;
  logic [7:0]        lines_nxt;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[3:2];

  always_comb begin
    unique case (cfg_index)
      ssp_pkg::REG_BOARD_SELECT:   prdata = {30'd0, board_select_r};
      ssp_pkg::REG_SLOT_PERIOD:    prdata = {16'd0, slot_period_r};
      ssp_pkg::REG_PULSE_OFFSET:   prdata = {16'd0, pulse_offset_r};
      ssp_pkg::REG_POSITION_LIMIT: prdata = {16'd0, position_limit_r};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_select_r   <= ssp_pkg::BOARD_RESET;
      slot_period_r    <= ssp_pkg::PERIOD_RESET;
      pulse_offset_r   <= ssp_pkg::OFFSET_RESET;
      position_limit_r <= ssp_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssp_pkg::REG_BOARD_SELECT:   board_select_r   <= pwdata[1:0];
        ssp_pkg::REG_SLOT_PERIOD:    slot_period_r    <= pwdata[15:0];
        ssp_pkg::REG_PULSE_OFFSET:   pulse_offset_r   <= pwdata[15:0];
        ssp_pkg::REG_POSITION_LIMIT: position_limit_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // The processing stage moves whenever the result register is free or being taken.
  assign advance   = !out_valid_r || out_ready;
  assign process   = s1_valid_r && advance;
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_servo_lines = out_lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_byte_r   <= in_rx_byte;
    end
    if (process) out_lines_r <= lines_nxt;
  end

  ssp_parser #(.NUM_CHANNELS(NUM_CHANNELS)) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_en        (process && s1_action_r == ssp_pkg::ACT_BYTE),
    .rx_byte        (s1_byte_r),
    .board_select   (board_select_r),
    .position_limit (position_limit_r),
    .cmd            (cmd),
    .cmd_chan       (cmd_chan)
  );

  // A copy moves every cached position into the live store at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        live_pos_r[i]  <= ssp_pkg::POS_RESET;
        cache_pos_r[i] <= ssp_pkg::POS_RESET;
      end
    end else begin
      if (cmd.wr_live) live_pos_r[cmd_chan] <= cmd.value;
      if (cmd.wr_cache) cache_pos_r[cmd_chan] <= cmd.value;
      if (cmd.copy_all) live_pos_r <= cache_pos_r;
    end
  end

  ssp_slot_timer #(.NUM_CHANNELS(NUM_CHANNELS)) u_timer (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_en      (process && s1_action_r == ssp_pkg::ACT_TICK),
    .slot_period  (slot_period_r),
    .pulse_offset (pulse_offset_r),
    .live_pos     (live_pos_r),
    .lines_nxt    (lines_nxt)
  );

endmodule

/* hw/rtl/ssp_parser.sv */
// Packet parser of the serial servo pulse controller.
// Depends on ssp_pkg for phase codes, framing constants and pos_cmd_t.
module ssp_parser #(
  parameter int NUM_CHANNELS = ssp_pkg::NUM_CHANNELS_DEF,
  localparam int CW = $clog2(NUM_CHANNELS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_en,
  input  logic [7:0]        rx_byte,
  input  logic [1:0]        board_select,
  input  logic [15:0]       position_limit,
  output ssp_pkg::pos_cmd_t cmd,
  output logic [CW-1:0]     cmd_chan
);

  localparam logic [6:0] NCH = 7'(NUM_CHANNELS);

  ssp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      addr_r, addr_nxt;
  logic [7:0]      high_r, high_nxt;

  logic [6:0]  base;
  logic [6:0]  rx_low5, addr_low5, addr_diff;
  logic        rx_match, addr_match;
  logic [15:0] raw_value;

  assign base      = 7'(board_select) * NCH;
  assign rx_low5   = 7'(rx_byte & ssp_pkg::ADDR_MASK);
  assign addr_low5 = 7'(addr_r & ssp_pkg::ADDR_MASK);
  assign rx_match  = (rx_low5 >= base) && (rx_low5 < base + NCH);
  assign addr_match = (addr_low5 >= base) && (addr_low5 < base + NCH);
  assign addr_diff = addr_low5 - base;
  assign cmd_chan  = addr_diff[CW-1:0];
  assign raw_value = {high_r, rx_byte};

  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    high_nxt  = high_r;
    if (byte_en) begin
      unique case (phase_r)
        ssp_pkg::PH_SYNC: begin
          if (rx_byte == ssp_pkg::SYNC_BYTE) phase_nxt = ssp_pkg::PH_ADDR;
        end
        ssp_pkg::PH_ADDR: begin
          addr_nxt = rx_byte;
          if (rx_match || rx_byte == ssp_pkg::COPY_ADDR) phase_nxt = ssp_pkg::PH_HIGH;
          else phase_nxt = ssp_pkg::PH_SKIP1;
        end
        ssp_pkg::PH_HIGH: begin
          high_nxt  = rx_byte;
          phase_nxt = ssp_pkg::PH_LOW;
        end
        ssp_pkg::PH_SKIP1: phase_nxt = ssp_pkg::PH_SKIP2;
        default: phase_nxt = ssp_pkg::PH_SYNC;
      endcase
    end
  end

  // The command fires on the low byte; the value is clamped to the limit.
  always_comb begin
    cmd.wr_live  = 1'b0;
    cmd.wr_cache = 1'b0;
    cmd.copy_all = 1'b0;
    cmd.value    = (raw_value > position_limit) ? position_limit : raw_value;
    if (byte_en && phase_r == ssp_pkg::PH_LOW) begin
      priority if (addr_r < ssp_pkg::LIVE_LIMIT) begin
        cmd.wr_live = addr_match;
      end else if (addr_r < ssp_pkg::CACHE_LIMIT) begin
        cmd.wr_cache = addr_match;
      end else if (addr_r == ssp_pkg::COPY_ADDR) begin
        cmd.copy_all = 1'b1;
      end else begin
        // Other high addresses are taken but change nothing.
        cmd.copy_all = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ssp_pkg::PH_SYNC;
      addr_r  <= 8'd0;
      high_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

/* hw/rtl/ssp_slot_timer.sv */
// Slot and pulse timing of the serial servo pulse controller.
// Depends on ssp_pkg; reads the live positions from the top level.
module ssp_slot_timer #(
  parameter int NUM_CHANNELS = ssp_pkg::NUM_CHANNELS_DEF,
  localparam int CW = $clog2(NUM_CHANNELS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         tick_en,
  input  logic [15:0]                  slot_period,
  input  logic [15:0]                  pulse_offset,
  input  logic [NUM_CHANNELS-1:0][15:0] live_pos,
  output logic [7:0]                   lines_nxt
);

  localparam logic [CW-1:0] LAST_CH = CW'(NUM_CHANNELS - 1);

  logic [15:0]   slot_timer_r, slot_timer_nxt;
  logic [CW-1:0] slot_chan_r, slot_chan_nxt;
  logic [15:0]   pulse_timer_r, pulse_timer_nxt;
  logic [15:0]   pulse_len_r, pulse_len_nxt;
  logic          pulse_active_r, pulse_active_nxt;
  logic [7:0]    lines_r;

  logic [15:0]   slot_inc, pulse_inc;
  logic [CW-1:0] next_chan;
  logic [16:0]   len_sum;
  logic          slot_start;

  assign slot_inc   = slot_timer_r + 16'd1;
  assign pulse_inc  = pulse_timer_r + 16'd1;
  assign slot_start = slot_inc >= slot_period;
  assign next_chan  = (slot_chan_r == LAST_CH) ? '0 : slot_chan_r + CW'(1);
  assign len_sum    = {1'b0, pulse_offset} + {1'b0, live_pos[next_chan]};

  always_comb begin
    slot_timer_nxt   = slot_timer_r;
    slot_chan_nxt    = slot_chan_r;
    pulse_timer_nxt  = pulse_timer_r;
    pulse_len_nxt    = pulse_len_r;
    pulse_active_nxt = pulse_active_r;
    lines_nxt        = lines_r;
    if (tick_en) begin
      // A running pulse is counted before the slot timer moves.
      if (pulse_active_r) begin
        pulse_timer_nxt = pulse_inc;
        if (pulse_inc >= pulse_len_r) begin
          lines_nxt        = 8'd0;
          pulse_active_nxt = 1'b0;
        end
      end
      slot_timer_nxt = slot_inc;
      if (slot_start) begin
        slot_timer_nxt   = 16'd0;
        slot_chan_nxt    = next_chan;
        pulse_len_nxt    = len_sum[16] ? 16'hFFFF : len_sum[15:0];
        pulse_timer_nxt  = 16'd0;
        pulse_active_nxt = 1'b1;
        // Channels numbered eight and above have no line.
        for (int i = 0; i < 8; i++) begin
          lines_nxt[i] = (int'(next_chan) == i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_timer_r   <= 16'd0;
      slot_chan_r    <= LAST_CH;
      pulse_timer_r  <= 16'd0;
      pulse_len_r    <= 16'd0;
      pulse_active_r <= 1'b0;
      lines_r        <= 8'd0;
    end else begin
      slot_timer_r   <= slot_timer_nxt;
      slot_chan_r    <= slot_chan_nxt;
      pulse_timer_r  <= pulse_timer_nxt;
      pulse_len_r    <= pulse_len_nxt;
      pulse_active_r <= pulse_active_nxt;
      lines_r        <= lines_nxt;
    end
  end

endmodule

/* hw/rtl/ssp_checker.sv */
// Port-level checks for the serial servo pulse controller.
// Depends on the top level's ports only; bound to serial_servo_pulse_controller below.
module ssp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_servo_lines,
  input logic       pready
);

  // At most one servo line is high while a result is valid.
  a_one_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_servo_lines))
    else $error("more than one servo line high");

  // The input side only stalls behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // A new result follows an accepted item.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an accepted item");

  // A waiting result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_servo_lines)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind serial_servo_pulse_controller ssp_checker u_ssp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_servo_lines (out_servo_lines),
  .pready          (pready)
);

/* tb/serial_servo_pulse_controller_tb.sv */
// Self-checking testbench for the serial servo pulse controller.
// Holds a line-level predictor and scoreboard class; depends on ssp_pkg and the RTL top level.
`timescale 1ns / 1ps

module serial_servo_pulse_controller_tb;

  localparam int CHANNELS = ssp_pkg::NUM_CHANNELS_DEF;

  // Predicts the servo line levels after each accepted item and checks the
  // results in order against those predictions.
  class servo_scoreboard;
    logic [1:0]  board;
    logic [15:0] slot_period;
    logic [15:0] pulse_offset;
    logic [15:0] position_limit;

    ssp_pkg::phase_t parse_phase;
    logic [7:0]  addr_latch;
    logic [7:0]  high_latch;
    logic [15:0] live_pos[CHANNELS];
    logic [15:0] cache_pos[CHANNELS];
    logic [15:0] slot_count;
    int          slot_ch;
    logic [15:0] pulse_count;
    logic [15:0] pulse_len;
    bit          pulse_on;
    logic [7:0]  lines;

    logic [7:0]  expected_lines[$];
    int          errors;

    function new();
      board          = ssp_pkg::BOARD_RESET;
      slot_period    = ssp_pkg::PERIOD_RESET;
      pulse_offset   = ssp_pkg::OFFSET_RESET;
      position_limit = ssp_pkg::LIMIT_RESET;
      parse_phase    = ssp_pkg::PH_SYNC;
      addr_latch     = '0;
      high_latch     = '0;
      for (int i = 0; i < CHANNELS; i++) begin
        live_pos[i]  = ssp_pkg::POS_RESET;
        cache_pos[i] = ssp_pkg::POS_RESET;
      end
      slot_count  = '0;
      slot_ch     = CHANNELS - 1;
      pulse_count = '0;
      pulse_len   = '0;
      pulse_on    = 1'b0;
      lines       = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        ssp_pkg::REG_BOARD_SELECT:   board = value[1:0];
        ssp_pkg::REG_SLOT_PERIOD:    slot_period = value[15:0];
        ssp_pkg::REG_PULSE_OFFSET:   pulse_offset = value[15:0];
        ssp_pkg::REG_POSITION_LIMIT: position_limit = value[15:0];
        default: ;
      endcase
    endfunction

    // Advances the parser or the slot timing by one item and queues the lines.
    function void note_item(logic action, logic [7:0] b);
      int          base;
      int          ch;
      logic [15:0] value;
      logic [16:0] sum;
      base = int'(board) * CHANNELS;
      if (action == ssp_pkg::ACT_BYTE) begin
        case (parse_phase)
          ssp_pkg::PH_SYNC: if (b == ssp_pkg::SYNC_BYTE) parse_phase = ssp_pkg::PH_ADDR;
          ssp_pkg::PH_ADDR: begin
            addr_latch = b;
            if ((int'(b & ssp_pkg::ADDR_MASK) >= base &&
                 int'(b & ssp_pkg::ADDR_MASK) < base + CHANNELS) ||
                b == ssp_pkg::COPY_ADDR)
              parse_phase = ssp_pkg::PH_HIGH;
            else
              parse_phase = ssp_pkg::PH_SKIP1;
          end
          ssp_pkg::PH_HIGH: begin
            high_latch = b;
            parse_phase = ssp_pkg::PH_LOW;
          end
          ssp_pkg::PH_LOW: begin
            parse_phase = ssp_pkg::PH_SYNC;
            value = {high_latch, b};
            if (value > position_limit) value = position_limit;
            ch = int'(addr_latch & ssp_pkg::ADDR_MASK) - base;
            if (addr_latch < ssp_pkg::LIVE_LIMIT) begin
              if (ch >= 0 && ch < CHANNELS) live_pos[ch] = value;
            end else if (addr_latch < ssp_pkg::CACHE_LIMIT) begin
              if (ch >= 0 && ch < CHANNELS) cache_pos[ch] = value;
            end else if (addr_latch == ssp_pkg::COPY_ADDR) begin
              for (int i = 0; i < CHANNELS; i++) live_pos[i] = cache_pos[i];
            end
          end
          ssp_pkg::PH_SKIP1: parse_phase = ssp_pkg::PH_SKIP2;
          default: parse_phase = ssp_pkg::PH_SYNC;
        endcase
      end else begin
        if (pulse_on) begin
          pulse_count = pulse_count + 16'd1;
          if (pulse_count >= pulse_len) begin
            lines = '0;
            pulse_on = 1'b0;
          end
        end
        slot_count = slot_count + 16'd1;
        if (slot_count >= slot_period) begin
          slot_count = '0;
          slot_ch = (slot_ch + 1 >= CHANNELS) ? 0 : slot_ch + 1;
          sum = {1'b0, pulse_offset} + {1'b0, live_pos[slot_ch]};
          pulse_len = sum[16] ? 16'hFFFF : sum[15:0];
          pulse_count = '0;
          pulse_on = 1'b1;
          lines = (slot_ch < 8) ? 8'(1 << slot_ch) : 8'h00;
        end
      end
      expected_lines.push_back(lines);
    endfunction

    function void check_lines(logic [7:0] actual);
      logic [7:0] want;
      if (expected_lines.size() == 0) begin
        $display("%0t: unexpected result, servo_lines actual %02h", $time, actual);
        errors++;
      end else begin
        want = expected_lines.pop_front();
        if (actual !== want) begin
          $display("%0t: servo_lines mismatch, expected %02h actual %02h", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = ssp_pkg::ACT_BYTE;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_servo_lines;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  servo_scoreboard sb = new();

  // When steady is set neither side idles. A nonzero hold_cycles asks the
  // receiver to hold off while items keep arriving; it sets the hold-off's length.
  bit steady = 1'b0;
  int hold_cycles = 0;

  serial_servo_pulse_controller DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_servo_lines (out_servo_lines),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, with the occasional long one.
  function automatic int gap_length();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Both handshakes are sampled at the edge, before any of this edge's
  // nonblocking updates take effect, so accepted items are seen exactly once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_action, in_rx_byte);
      if (out_valid && out_ready) sb.check_lines(out_servo_lines);
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        gap = gap_length();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Offers one item, after a random gap, and returns at the edge that accepts it.
  task automatic send_item(logic action, logic [7:0] b);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= action;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Drives a setup phase, then an access phase, then leaves the port idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic setup(int board, int period, int offset, int limit);
    write_reg(ssp_pkg::REG_BOARD_SELECT, 32'(board));
    write_reg(ssp_pkg::REG_SLOT_PERIOD, 32'(period));
    write_reg(ssp_pkg::REG_PULSE_OFFSET, 32'(offset));
    write_reg(ssp_pkg::REG_POSITION_LIMIT, 32'(limit));
  endtask

  // Mostly well-formed packets with random content, tick bursts that run the
  // slots, and some stray bytes and truncated packets.
  task automatic run_random(int n);
    int         sent;
    int         r;
    int         k;
    int         base;
    int         ch;
    logic [7:0] a;
    logic [7:0] hi;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        base = int'(sb.board) * CHANNELS;
        ch = $urandom_range(0, CHANNELS - 1);
        case ($urandom_range(0, 5))
          0, 1: a = 8'(base + ch);
          2: a = 8'(ssp_pkg::LIVE_LIMIT + base + ch);
          3: a = ssp_pkg::COPY_ADDR;
          // Higher address bits with a valid servo number: taken but ignored, unless it forms the copy address.
          4: a = 8'($urandom_range(2, 7) * 32 + base + ch);
          default: begin
            // Servo number of another board: the rest of the packet is skipped.
            do a = 8'($urandom);
            while ((int'(a & ssp_pkg::ADDR_MASK) >= base &&
                    int'(a & ssp_pkg::ADDR_MASK) < base + CHANNELS) ||
                   a == ssp_pkg::COPY_ADDR);
          end
        endcase
        case ($urandom_range(0, 3))
          0: hi = 8'h00;
          1: hi = 8'hFF;
          default: hi = 8'($urandom);
        endcase
        send_item(ssp_pkg::ACT_BYTE, ssp_pkg::SYNC_BYTE);
        send_item(ssp_pkg::ACT_BYTE, a);
        send_item(ssp_pkg::ACT_BYTE, hi);
        send_item(ssp_pkg::ACT_BYTE, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
        sent += 4;
      end else if (r < 85) begin
        k = $urandom_range(1, 12);
        repeat (k) send_item(ssp_pkg::ACT_TICK, 8'($urandom));
        sent += k;
      end else if (r < 93) begin
        send_item(ssp_pkg::ACT_BYTE, 8'($urandom));
        sent += 1;
      end else begin
        k = $urandom_range(0, 1);
        send_item(ssp_pkg::ACT_BYTE, ssp_pkg::SYNC_BYTE);
        send_item(ssp_pkg::ACT_BYTE, 8'($urandom));
        if (k == 1) send_item(ssp_pkg::ACT_BYTE, 8'($urandom));
        sent += 2 + k;
      end
    end
  endtask

  initial begin : stimulus
    int limit;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks under the reset settings leave every line low.
    send_item(ssp_pkg::ACT_TICK, 8'h00);
    send_item(ssp_pkg::ACT_TICK, 8'hFF);
    drain();

    // Directed: short slots, board one, no clamping beyond the full range.
    setup(1, 2, 1, 16'hFFFF);
    // Live write of channel zero with 255 as both data bytes.
    send_item(ssp_pkg::ACT_BYTE, ssp_pkg::SYNC_BYTE);
    send_item(ssp_pkg::ACT_BYTE, 8'(CHANNELS));
    send_item(ssp_pkg::ACT_BYTE, 8'hFF);
    send_item(ssp_pkg::ACT_BYTE, 8'hFF);
    // Cached write of zero to channel zero.
    send_item(ssp_pkg::ACT_BYTE, ssp_pkg::SYNC_BYTE);
    send_item(ssp_pkg::ACT_BYTE, 8'(ssp_pkg::LIVE_LIMIT + CHANNELS));
    send_item(ssp_pkg::ACT_BYTE, 8'h00);
    send_item(ssp_pkg::ACT_BYTE, 8'h00);
    // Servo number of board zero: skipped.
    send_item(ssp_pkg::ACT_BYTE, ssp_pkg::SYNC_BYTE);
    send_item(ssp_pkg::ACT_BYTE, 8'h00);
    send_item(ssp_pkg::ACT_BYTE, 8'h01);
    send_item(ssp_pkg::ACT_BYTE, 8'h02);
    // Copy the cache into the live positions.
    send_item(ssp_pkg::ACT_BYTE, ssp_pkg::SYNC_BYTE);
    send_item(ssp_pkg::ACT_BYTE, ssp_pkg::COPY_ADDR);
    send_item(ssp_pkg::ACT_BYTE, 8'h12);
    send_item(ssp_pkg::ACT_BYTE, 8'h34);
    repeat (6) send_item(ssp_pkg::ACT_TICK, 8'($urandom));
    drain();

    // Zero slot period, zero pulse offset and a zero position limit.
    setup(0, 0, 0, 0);
    run_random(150);
    drain();

    // Every register at its top value.
    setup(3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150);
    drain();

    // Saturated pulse lengths cut off by the next slot, with a long receiver
    // hold-off so the block backs up into its input.
    setup(2, 6, 16'hFFFF, 16'hFFFF);
    hold_cycles = 400;
    run_random(150);
    drain();

    // Back-to-back items with no idling on either side.
    steady = 1'b1;
    setup(1, 1, 0, 3);
    run_random(150);
    drain();
    steady = 1'b0;

    for (int p = 0; p < 6; p++) begin
      limit = ($urandom_range(0, 4) == 0) ? 16'hFFFF : $urandom_range(0, 40);
      setup($urandom_range(0, 3), ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40),
            $urandom_range(0, 16), limit);
      run_random(150);
      drain();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* serial_servo_pulse_controller.f */
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_parser.sv
hw/rtl/ssp_slot_timer.sv
hw/rtl/serial_servo_pulse_controller.sv
hw/rtl/ssp_checker.sv
tb/serial_servo_pulse_controller_tb.sv
